// ===== sv/snfce_pkg.sv =====
`timescale 1ns / 1ps
package snfce_pkg;

    localparam int FLASH_BYTES   = 262144;
    localparam int PAGE_BYTES    = 256;
    localparam int SECTOR_BYTES  = 4096;
    localparam int BLOCK32_BYTES = 32768;
    localparam int BLOCK64_BYTES = 65536;
    localparam int HEADER_BYTES  = 5;

    // flash size is a power of two: the address wraps by masking
    localparam int ADDR_W = $clog2(FLASH_BYTES);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int PAGE_W = $clog2(PAGE_BYTES);
    localparam int HCNT_W = $clog2(HEADER_BYTES + 1);

    localparam int SECTOR_LEN  = (SECTOR_BYTES  < FLASH_BYTES) ? SECTOR_BYTES  : FLASH_BYTES;
    localparam int BLOCK32_LEN = (BLOCK32_BYTES < FLASH_BYTES) ? BLOCK32_BYTES : FLASH_BYTES;
    localparam int BLOCK64_LEN = (BLOCK64_BYTES < FLASH_BYTES) ? BLOCK64_BYTES : FLASH_BYTES;

    localparam logic [7:0] OP_WREN    = 8'h06;
    localparam logic [7:0] OP_WRDI    = 8'h04;
    localparam logic [7:0] OP_STATUS  = 8'h05;
    localparam logic [7:0] OP_READ    = 8'h03;
    localparam logic [7:0] OP_PROGRAM = 8'h02;
    localparam logic [7:0] OP_SECTOR  = 8'h20;
    localparam logic [7:0] OP_BLOCK32 = 8'h52;
    localparam logic [7:0] OP_BLOCK64 = 8'hd8;
    localparam logic [7:0] OP_CHIP1   = 8'hc7;
    localparam logic [7:0] OP_CHIP2   = 8'h60;
    localparam logic [7:0] OP_ID      = 8'h90;
    localparam logic [7:0] OP_UID     = 8'h4b;

    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_SELECT  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] REG_UID   = 2'd0;
    localparam logic [1:0] REG_MAKER = 2'd1;
    localparam logic [1:0] REG_PART  = 2'd2;

    localparam logic [63:0] UID_RESET   = 64'hdeadbeefdeadbeef;
    localparam logic [7:0]  MAKER_RESET = 8'd239;
    localparam logic [7:0]  PART_RESET  = 8'd17;

    typedef enum logic [1:0] {PH_IDLE, PH_LOADING, PH_RUNNING} t_phase;
    typedef enum logic [1:0] {SW_CLEAR, SW_ERASE, SW_LOAD, SW_PROG} t_sweep;
    typedef enum logic [1:0] {REQ_NONE, REQ_OUT, REQ_READ, REQ_SWEEP} t_req;

    typedef struct packed {
        logic accept;
        logic take_read;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        t_req req;
    } t_dp_stat;

endpackage

// ===== sv/spi_nor_flash_command_engine.sv =====
`timescale 1ns / 1ps
// channel   | handshake                 | payload
// input     | i_in_valid / o_in_ready   | i_command, i_data_byte
// output    | o_out_valid / i_out_ready | o_out_byte
// config    | i_cfg_wr_en               | i_cfg_index, i_cfg_wr_data
//
// One item at a time: a byte that answers from registers goes out through the
// output register, a read data byte first through the registered flash read port.
// Page program start and program commit hold o_in_ready low after the transfer while
// the page is swept, an erase while its region is, chip erase while the whole flash
// is: one flash byte a cycle. After reset the flash is erased in a clearing pass with
// o_in_ready low; config writes are taken throughout. A stalled output holds.
module spi_nor_flash_command_engine import snfce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wr_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    snfce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    snfce_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .o_out_byte    (o_out_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

endmodule

// ===== sv/snfce_ctrl.sv =====
`timescale 1ns / 1ps
module snfce_ctrl import snfce_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_SWEEP = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RD    = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.accept    = i_in_valid && o_in_ready;
    assign o_cmd.take_read = (r_state == S_RD);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_SWEEP: begin
                if (!i_stat.busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_cmd.accept) begin
                    case (i_stat.req)
                        REQ_OUT:   n_state = S_OUT;
                        REQ_READ:  n_state = S_RD;
                        REQ_SWEEP: n_state = S_SWEEP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RD:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_SWEEP;
        endcase
    end

    // reset enters the sweep state: the flash is being erased
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_SWEEP;
        else          r_state <= n_state;
    end

endmodule

// ===== sv/snfce_datapath.sv =====
`timescale 1ns / 1ps
module snfce_datapath import snfce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    output logic [7:0]  o_out_byte,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wr_data
);

    logic [7:0] flash_mem [FLASH_BYTES];
    logic [7:0] page_mem  [PAGE_BYTES];

    logic [63:0]       r_uid;
    logic [7:0]        r_maker, r_part;
    logic [7:0]        r_hdr1, n_hdr1, r_hdr2, n_hdr2;
    logic [HCNT_W-1:0] r_hcnt, n_hcnt;
    logic [7:0]        r_opcode, n_opcode;
    logic [ADDR_W-1:0] r_cursor, n_cursor;
    t_phase            r_phase, n_phase;
    logic              r_we, n_we;
    logic [7:0]        r_out, n_out;
    logic [7:0]        r_rdata, r_prdata;

    logic              r_busy;
    t_sweep            r_kind, n_kind;
    logic [CNT_W-1:0]  r_idx, r_len, n_len;
    logic [ADDR_W-1:0] r_base, n_base;
    logic              sw_start;

    t_req              req;
    logic              pg_run_we;
    logic [7:0]        op_n;
    logic [HCNT_W-1:0] cnt_n;
    logic [23:0]       addr24;

    logic              fl_we, pg_we;
    logic [ADDR_W-1:0] fl_ra, fl_wa;
    logic [7:0]        fl_wd, pg_wd;
    logic [PAGE_W-1:0] pg_wa;
    logic [ADDR_W-1:0] idx_m1;

    function automatic logic [ADDR_W-1:0] page_base(input logic [ADDR_W-1:0] a);
        return {a[ADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
    endfunction

    function automatic logic [ADDR_W-1:0] region_base(input logic [ADDR_W-1:0] a,
                                                      input logic [CNT_W-1:0]  len);
        logic [CNT_W-1:0] m;
        m = len - CNT_W'(1);
        return a & ~m[ADDR_W-1:0];
    endfunction

    function automatic logic [7:0] uid_byte(input logic [63:0] u, input logic [3:0] c);
        logic [7:0] b;
        case (c)
            4'd1:    b = u[7:0];
            4'd2:    b = u[15:8];
            4'd3:    b = u[23:16];
            4'd4:    b = u[31:24];
            4'd5:    b = u[39:32];
            4'd6:    b = u[47:40];
            4'd7:    b = u[55:48];
            4'd8:    b = u[63:56];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    assign o_stat.busy = r_busy;
    assign o_stat.req  = req;
    assign o_out_byte  = r_out;

    always_comb begin
        n_hdr1    = r_hdr1;
        n_hdr2    = r_hdr2;
        n_hcnt    = r_hcnt;
        n_opcode  = r_opcode;
        n_cursor  = r_cursor;
        n_phase   = r_phase;
        n_we      = r_we;
        n_out     = r_out;
        n_kind    = r_kind;
        n_base    = r_base;
        n_len     = r_len;
        sw_start  = 1'b0;
        req       = REQ_NONE;
        pg_run_we = 1'b0;
        op_n      = (r_hcnt == '0) ? i_data_byte : r_opcode;
        cnt_n     = r_hcnt + HCNT_W'(1);
        addr24    = {r_hdr1, r_hdr2, i_data_byte};

        if (i_cmd.take_read) n_out = r_rdata;

        if (i_cmd.accept) begin
            case (i_command)
                CMD_SELECT: begin
                    n_phase  = PH_LOADING;
                    n_hcnt   = '0;
                    n_opcode = 8'h00;
                    n_cursor = '0;
                end
                CMD_RELEASE: begin
                    if (r_phase == PH_RUNNING) begin
                        case (r_opcode)
                            OP_WREN: n_we = 1'b1;
                            OP_WRDI: n_we = 1'b0;
                            OP_PROGRAM: begin
                                if (r_we) begin
                                    sw_start = 1'b1;
                                    n_kind   = SW_PROG;
                                    n_len    = CNT_W'(PAGE_BYTES);
                                    n_base   = page_base(r_cursor);
                                    n_we     = 1'b0;
                                end
                            end
                            OP_CHIP1, OP_CHIP2: begin
                                if (r_we) begin
                                    sw_start = 1'b1;
                                    n_kind   = SW_CLEAR;
                                    n_len    = CNT_W'(FLASH_BYTES);
                                    n_base   = '0;
                                    n_we     = 1'b0;
                                end
                            end
                            OP_SECTOR, OP_BLOCK32, OP_BLOCK64: begin
                                if (r_we) begin
                                    sw_start = 1'b1;
                                    n_kind   = SW_ERASE;
                                    if (r_opcode == OP_SECTOR)       n_len = CNT_W'(SECTOR_LEN);
                                    else if (r_opcode == OP_BLOCK32) n_len = CNT_W'(BLOCK32_LEN);
                                    else                             n_len = CNT_W'(BLOCK64_LEN);
                                    n_base   = region_base(r_cursor, n_len);
                                    n_we     = 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    n_phase = PH_IDLE;
                end
                CMD_BYTE: begin
                    if (r_phase == PH_LOADING) begin
                        // header bytes past the end are dropped
                        if (r_hcnt < HCNT_W'(HEADER_BYTES)) begin
                            n_hcnt   = cnt_n;
                            n_opcode = op_n;
                            if (r_hcnt == HCNT_W'(1)) n_hdr1 = i_data_byte;
                            if (r_hcnt == HCNT_W'(2)) n_hdr2 = i_data_byte;
                            if (op_n inside {OP_READ, OP_ID, OP_SECTOR, OP_BLOCK32,
                                             OP_BLOCK64, OP_PROGRAM}) begin
                                if (cnt_n == HCNT_W'(4)) begin
                                    n_cursor = addr24[ADDR_W-1:0];
                                    n_phase  = PH_RUNNING;
                                    if (op_n == OP_PROGRAM) begin
                                        sw_start = 1'b1;
                                        n_kind   = SW_LOAD;
                                        n_len    = CNT_W'(PAGE_BYTES);
                                        n_base   = page_base(addr24[ADDR_W-1:0]);
                                    end
                                end
                            end else if (op_n inside {OP_WREN, OP_WRDI, OP_STATUS,
                                                      OP_CHIP1, OP_CHIP2}) begin
                                n_phase = PH_RUNNING;
                            end else if (op_n == OP_UID) begin
                                if (cnt_n == HCNT_W'(5)) begin
                                    n_cursor = ADDR_W'(8);
                                    n_phase  = PH_RUNNING;
                                end
                            end
                        end
                    end else if (r_phase == PH_RUNNING) begin
                        case (r_opcode)
                            OP_ID: begin
                                n_out    = r_cursor[0] ? r_part : r_maker;
                                n_cursor = r_cursor + ADDR_W'(1);
                                req      = REQ_OUT;
                            end
                            OP_READ: begin
                                n_cursor = r_cursor + ADDR_W'(1);
                                req      = REQ_READ;
                            end
                            OP_STATUS: begin
                                n_out = {6'b0, r_we, 1'b0};
                                req   = REQ_OUT;
                            end
                            OP_UID: begin
                                if (r_cursor != '0 && r_cursor <= ADDR_W'(8)) begin
                                    n_out    = uid_byte(r_uid, r_cursor[3:0]);
                                    n_cursor = r_cursor - ADDR_W'(1);
                                    req      = REQ_OUT;
                                end
                            end
                            OP_PROGRAM: begin
                                pg_run_we = 1'b1;
                                n_cursor  = {r_cursor[ADDR_W-1:PAGE_W],
                                             r_cursor[PAGE_W-1:0] + PAGE_W'(1)};
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
        if (sw_start) req = REQ_SWEEP;
    end

    // sweep: read at idx, write the entry before it in the next cycle from the registered read
    assign idx_m1 = r_idx[ADDR_W-1:0] - ADDR_W'(1);
    assign fl_ra  = r_busy ? r_base + r_idx[ADDR_W-1:0] : r_cursor;
    assign fl_wa  = r_base + idx_m1;
    assign fl_we  = r_busy && (r_idx != '0) && (r_kind != SW_LOAD);
    assign fl_wd  = (r_kind == SW_PROG) ? (r_rdata & r_prdata) : 8'hFF;
    assign pg_we  = (r_busy && (r_idx != '0) && (r_kind == SW_LOAD)) || pg_run_we;
    assign pg_wa  = r_busy ? idx_m1[PAGE_W-1:0] : r_cursor[PAGE_W-1:0];
    assign pg_wd  = r_busy ? r_rdata : i_data_byte;

    always_ff @(posedge i_clk) begin
        if (fl_we) flash_mem[fl_wa] <= fl_wd;
        r_rdata <= flash_mem[fl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pg_we) page_mem[pg_wa] <= pg_wd;
        r_prdata <= page_mem[r_idx[PAGE_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_hdr1 <= n_hdr1;
        r_hdr2 <= n_hdr2;
        if (!i_rst_n) begin
            r_uid    <= UID_RESET;
            r_maker  <= MAKER_RESET;
            r_part   <= PART_RESET;
            r_hcnt   <= '0;
            r_opcode <= 8'h00;
            r_cursor <= '0;
            r_phase  <= PH_IDLE;
            r_we     <= 1'b0;
            r_busy   <= 1'b1;
            r_kind   <= SW_CLEAR;
            r_idx    <= '0;
            r_base   <= '0;
            r_len    <= CNT_W'(FLASH_BYTES);
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_UID:   r_uid   <= i_cfg_wr_data;
                    REG_MAKER: r_maker <= i_cfg_wr_data[7:0];
                    REG_PART:  r_part  <= i_cfg_wr_data[7:0];
                    default: ;
                endcase
            end
            r_hcnt   <= n_hcnt;
            r_opcode <= n_opcode;
            r_cursor <= n_cursor;
            r_phase  <= n_phase;
            r_we     <= n_we;
            r_kind   <= n_kind;
            r_base   <= n_base;
            r_len    <= n_len;
            if (sw_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (r_idx == r_len) r_busy <= 1'b0;
                else                r_idx  <= r_idx + CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/snfce_checker.sv =====
`timescale 1ns / 1ps
module snfce_checker import snfce_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_command,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte
);

    // one item in flight: no new transfer while a result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte)))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_ready))
        else $error("handshake active right after reset");

    a_select_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_command == CMD_SELECT || i_command == CMD_RELEASE))
        |=> !o_out_valid)
        else $error("chip select event produced a result");

endmodule

bind spi_nor_flash_command_engine snfce_checker u_snfce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_command   (i_command),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte)
);
